// ----- hw/rtl/wepf_pkg.sv -----
`timescale 1ns / 1ps

package wepf_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_LOAD_A = 2'd0;
	localparam kind_t KIND_LOAD_B = 2'd1;
	localparam kind_t KIND_RUN    = 2'd2;

endpackage

// ----- hw/rtl/wepf_ram.sv -----
`timescale 1ns / 1ps

module wepf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/widest_edge_pair_finder.sv -----
`timescale 1ns / 1ps

// Edge loads: one per cycle while no walk is running, no result, busy stays low.
// Run: result strobe (done) in the cycle after acceptance if either list is empty, else
// when the walk ends; the walk advances one B edge per cycle, set by the
// single registered read port of each edge RAM. busy is high during the walk.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset clears both counts, the overflow flag, the sequencer and done.
module widest_edge_pair_finder #(
	parameter int MAX_EDGES     = 64,
	parameter int POSITION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  wepf_pkg::kind_t          kind,
	input  logic [POSITION_BITS-1:0] position,
	output logic                     done,
	output logic                     found,
	output logic [POSITION_BITS-1:0] edge_a_position,
	output logic [POSITION_BITS-1:0] edge_b_position,
	output logic [POSITION_BITS-1:0] gap_width,
	output logic                     overflowed
);

	import wepf_pkg::*;

	localparam int AW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EDGES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                     state_q;
	logic [CW-1:0]            a_cnt_q;
	logic [CW-1:0]            b_cnt_q;
	logic                     ovf_q;
	logic [CW-1:0]            i_q;
	logic [CW-1:0]            j_q;
	logic                     have_q;
	logic [POSITION_BITS-1:0] best_a_q;
	logic [POSITION_BITS-1:0] best_b_q;
	logic [POSITION_BITS-1:0] best_gap_q;
	logic                     done_q;
	logic                     found_q;
	logic [POSITION_BITS-1:0] res_a_q;
	logic [POSITION_BITS-1:0] res_b_q;
	logic [POSITION_BITS-1:0] res_gap_q;
	logic                     res_ovf_q;

	logic                     accept;
	logic                     a_we;
	logic                     b_we;
	logic [AW-1:0]            a_raddr;
	logic [AW-1:0]            b_raddr;
	logic [POSITION_BITS-1:0] a_rdata;
	logic [POSITION_BITS-1:0] b_rdata;
	logic                     a_lt_b;
	logic [POSITION_BITS-1:0] gap;
	logic                     better;
	logic [CW-1:0]            i_n;
	logic [CW-1:0]            j_n;
	logic                     fin;
	logic                     nb_have;
	logic [POSITION_BITS-1:0] nb_a;
	logic [POSITION_BITS-1:0] nb_b;
	logic [POSITION_BITS-1:0] nb_gap;

	assign accept = start && (state_q == ST_IDLE);
	assign a_we   = accept && (kind == KIND_LOAD_A) && (a_cnt_q < CNT_MAX);
	assign b_we   = accept && (kind == KIND_LOAD_B) && (b_cnt_q < CNT_MAX);

	always_comb begin
		a_lt_b  = a_rdata < b_rdata;
		gap     = b_rdata - a_rdata;
		better  = a_lt_b && (gap > best_gap_q);
		i_n     = a_lt_b ? i_q + CW'(1) : i_q;
		j_n     = j_q + CW'(1);
		fin     = (i_n >= a_cnt_q) || (j_n >= b_cnt_q);
		nb_have = have_q || better;
		nb_a    = better ? a_rdata : best_a_q;
		nb_b    = better ? b_rdata : best_b_q;
		nb_gap  = better ? gap : best_gap_q;
		if (state_q == ST_WALK) begin
			a_raddr = i_n[AW-1:0];
			b_raddr = j_n[AW-1:0];
		end else begin
			a_raddr = '0;
			b_raddr = '0;
		end
	end

	wepf_ram #(.WIDTH(POSITION_BITS), .DEPTH(MAX_EDGES)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_cnt_q[AW-1:0]),
		.wdata (position),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	wepf_ram #(.WIDTH(POSITION_BITS), .DEPTH(MAX_EDGES)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_cnt_q[AW-1:0]),
		.wdata (position),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_LOAD_A: begin
								if (a_cnt_q < CNT_MAX) begin
									a_cnt_q <= a_cnt_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							KIND_LOAD_B: begin
								if (b_cnt_q < CNT_MAX) begin
									b_cnt_q <= b_cnt_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							KIND_RUN: begin
								if ((a_cnt_q == '0) || (b_cnt_q == '0)) begin
									done_q  <= 1'b1;
									a_cnt_q <= '0;
									b_cnt_q <= '0;
									ovf_q   <= 1'b0;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (fin) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						a_cnt_q <= '0;
						b_cnt_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			i_q        <= '0;
			j_q        <= '0;
			have_q     <= 1'b0;
			best_a_q   <= '0;
			best_b_q   <= '0;
			best_gap_q <= '0;
			if (accept && (kind == KIND_RUN)) begin
				found_q   <= 1'b0;
				res_a_q   <= '0;
				res_b_q   <= '0;
				res_gap_q <= '0;
				res_ovf_q <= ovf_q;
			end
		end else begin
			i_q        <= i_n;
			j_q        <= j_n;
			have_q     <= nb_have;
			best_a_q   <= nb_a;
			best_b_q   <= nb_b;
			best_gap_q <= nb_gap;
			if (fin) begin
				found_q   <= nb_have;
				res_a_q   <= nb_a;
				res_b_q   <= nb_b;
				res_gap_q <= nb_gap;
				res_ovf_q <= ovf_q;
			end
		end
	end

	assign busy            = (state_q == ST_WALK);
	assign done            = done_q;
	assign found           = found_q;
	assign edge_a_position = res_a_q;
	assign edge_b_position = res_b_q;
	assign gap_width       = res_gap_q;
	assign overflowed      = res_ovf_q;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import wepf_pkg::*;

	localparam int DEPTH = 64;
	localparam int POS_W = 24;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam kind_t KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1100;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic found;
		pos_t a_pos;
		pos_t b_pos;
		pos_t gap;
		logic ovf;
	} pair_result_t;

	typedef struct packed {
		kind_t        kind;
		pos_t         pos;
		logic         typed;
		pair_result_t res;
	} stim_row_t;

	localparam pair_result_t NONE = '{1'b0, 24'h0, 24'h0, 24'h0, 1'b0};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	kind_t kind;
	pos_t position;
	logic done;
	logic found;
	pos_t edge_a_position;
	pos_t edge_b_position;
	pos_t gap_width;
	logic overflowed;

	widest_edge_pair_finder #(
		.MAX_EDGES    (DEPTH),
		.POSITION_BITS(POS_W)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.position       (position),
		.done           (done),
		.found          (found),
		.edge_a_position(edge_a_position),
		.edge_b_position(edge_b_position),
		.gap_width      (gap_width),
		.overflowed     (overflowed)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predictor state
	pos_t a_edges [DEPTH];
	pos_t b_edges [DEPTH];
	int   a_count;
	int   b_count;
	logic dropped;

	pair_result_t pending_pairs [$];
	int mismatches;
	int items_sent;

	// Accepted transfer: update the edge lists, and for a run return the widest pair.
	function automatic bit track_edges(kind_t k, pos_t p, output pair_result_t r);
		int j;
		pos_t gap;
		r = NONE;
		j = 0;
		case (k)
			KIND_LOAD_A: begin
				if (a_count < DEPTH) begin
					a_edges[a_count] = p;
					a_count++;
				end else
					dropped = 1'b1;
				return 1'b0;
			end
			KIND_LOAD_B: begin
				if (b_count < DEPTH) begin
					b_edges[b_count] = p;
					b_count++;
				end else
					dropped = 1'b1;
				return 1'b0;
			end
			KIND_RUN: begin
				for (int i = 0; i < a_count; i++) begin
					while (j < b_count && a_edges[i] >= b_edges[j])
						j++;
					if (j >= b_count)
						break;
					gap = b_edges[j] - a_edges[i];
					if (gap > r.gap) begin
						r.gap = gap;
						r.a_pos = a_edges[i];
						r.b_pos = b_edges[j];
						r.found = 1'b1;
					end
					j++;
				end
				r.ovf = dropped;
				a_count = 0;
				b_count = 0;
				dropped = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic note_mismatch(string what, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
	endtask

	task automatic check_field(string what, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
		if (exp_v !== act_v)
			note_mismatch(what, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n && done) begin
			if (pending_pairs.size() == 0)
				note_mismatch("unexpected result, found", 'x, pos_t'(found));
			else begin
				want = pending_pairs.pop_front();
				check_field("found", pos_t'(want.found), pos_t'(found));
				check_field("edge_a_position", want.a_pos, edge_a_position);
				check_field("edge_b_position", want.b_pos, edge_b_position);
				check_field("gap_width", want.gap, gap_width);
				check_field("overflowed", pos_t'(want.ovf), pos_t'(overflowed));
			end
		end
	end

	// One transfer; start stays high across back-to-back items.
	task automatic send_item(kind_t k, pos_t p, int idle, logic typed = 1'b0,
			pair_result_t typed_res = NONE);
		pair_result_t r;
		if (idle > 0) begin
			start <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		position <= p;
		do @(posedge clk); while (busy);
		if (track_edges(k, p, r))
			pending_pairs.insert(pending_pairs.size(), typed ? typed_res : r);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	stim_row_t directed [24] = '{
		'{KIND_RUN,    24'h000000, 1'b1, NONE},
		'{KIND_UNUSED, POS_MAX,    1'b0, NONE},
		'{KIND_LOAD_A, 24'h000000, 1'b0, NONE},
		'{KIND_LOAD_B, POS_MAX,    1'b0, NONE},
		'{KIND_RUN,    24'h000000, 1'b1, '{1'b1, 24'h0, POS_MAX, POS_MAX, 1'b0}},
		'{KIND_LOAD_A, 24'h000005, 1'b0, NONE},
		'{KIND_LOAD_B, 24'h000005, 1'b0, NONE},
		'{KIND_RUN,    POS_MAX,    1'b1, NONE},
		'{KIND_LOAD_B, 24'h000007, 1'b0, NONE},
		'{KIND_RUN,    24'h000000, 1'b1, NONE},
		'{KIND_LOAD_A, 24'h000007, 1'b0, NONE},
		'{KIND_RUN,    24'h000000, 1'b1, NONE},
		'{KIND_LOAD_A, 24'h000100, 1'b0, NONE},
		'{KIND_LOAD_A, 24'h000050, 1'b0, NONE},
		'{KIND_LOAD_B, 24'h000050, 1'b0, NONE},
		'{KIND_LOAD_B, 24'h000200, 1'b0, NONE},
		'{KIND_RUN,    24'h000000, 1'b0, NONE},
		'{KIND_LOAD_A, 24'h000000, 1'b0, NONE},
		'{KIND_LOAD_A, 24'h000010, 1'b0, NONE},
		'{KIND_LOAD_B, 24'h000005, 1'b0, NONE},
		'{KIND_LOAD_B, 24'h000015, 1'b0, NONE},
		'{KIND_RUN,    24'h000000, 1'b0, NONE},
		'{KIND_LOAD_A, 24'h555555, 1'b0, NONE},
		'{KIND_LOAD_B, 24'hAAAAAA, 1'b0, NONE}
	};

	initial begin
		int n;
		int b_pct;
		int step_max;
		bit idle_on;
		logic [POS_W:0] cur;
		pos_t p;
		kind_t k;

		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_LOAD_A;
		position <= '0;
		a_count = 0;
		b_count = 0;
		dropped = 1'b0;
		mismatches = 0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].kind, directed[i].pos, $urandom_range(0, 12),
				directed[i].typed, directed[i].res);
		send_item(KIND_RUN, pos_t'($urandom), 0);

		while (items_sent < RANDOM_ITEMS + 25) begin
			idle_on = ($urandom_range(0, 9) < 7);
			if ($urandom_range(0, 99) < 8) begin
				// noise, including the unused kind
				n = $urandom_range(1, 6);
				repeat (n)
					send_item(kind_t'($urandom_range(0, 3)), pos_t'($urandom),
						idle_on ? $urandom_range(0, 12) : 0);
			end else begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 140)
					: $urandom_range(0, 10);
				b_pct = $urandom_range(20, 80);
				case ($urandom_range(0, 3))
					0: step_max = 3;
					1: step_max = 255;
					2: step_max = 'h00FFFF;
					default: step_max = 'h3FFFFF;
				endcase
				cur = (POS_W + 1)'($urandom_range(0, POS_MAX) >> $urandom_range(0, 23));
				repeat (n) begin
					cur = (POS_W + 1)'(cur + $urandom_range(0, step_max));
					if (cur > POS_MAX)
						cur = POS_MAX;
					p = cur[POS_W-1:0];
					if ($urandom_range(0, 29) == 0)
						p = pos_t'($urandom);
					k = ($urandom_range(0, 99) < b_pct) ? KIND_LOAD_B : KIND_LOAD_A;
					send_item(k, p, idle_on ? $urandom_range(0, 12) : 0);
				end
				send_item(KIND_RUN, pos_t'($urandom), idle_on ? $urandom_range(0, 12) : 0);
			end
		end
		start <= 1'b0;

		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (pending_pairs.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
